>>> rtl/row_repeat_rle_frame_decoder_macros.svh
// Assertion macros used by the checker file of the frame decoder.
`ifndef ROW_REPEAT_RLE_FRAME_DECODER_MACROS_SVH
`define ROW_REPEAT_RLE_FRAME_DECODER_MACROS_SVH

// Checked at every rising edge outside reset.
`define RRD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define RRD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> rtl/rrd_pkg.sv
// Types, codes and constants of the row-repeat run-length frame decoder.
`default_nettype none

package rrd_pkg;

  localparam int unsigned InkLimit = 8;
  localparam logic [16:0] VarSat   = 17'h1FFFF;
  localparam int unsigned OutDepth = 4;
  localparam int unsigned OutPtrW  = $clog2(OutDepth);
  localparam int unsigned OutCntW  = $clog2(OutDepth + 1);
  localparam int unsigned MaxPerBeat = 3;

  typedef enum logic [5:0] {
    PhHeader  = 6'b000001,
    PhRepeat  = 6'b000010,
    PhRunHdr  = 6'b000100,
    PhRunLen  = 6'b001000,
    PhDone    = 6'b010000,
    PhDiscard = 6'b100000
  } phase_e;

  typedef enum logic [1:0] {
    KindHeader = 2'd0,
    KindFill   = 2'd1,
    KindCopy   = 2'd2,
    KindStatus = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StBad     = 2'd1,
    StNoSpace = 2'd2
  } status_e;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] row;
    logic [15:0] col;
    logic [15:0] length;
    logic [2:0]  ink;
    logic [15:0] width;
    logic [15:0] height;
    status_e     status;
    logic        last_of_item;
  } result_t;

  // Expected bytes of the four-byte frame signature.
  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] v;
    unique case (idx)
      2'd0:    v = 8'h55;
      2'd1:    v = 8'h46;
      2'd2:    v = 8'h42;
      default: v = 8'h32;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

>>> rtl/rrd_if.sv
// Valid/ready channel interfaces for the encoded byte beats and the result beats.
`default_nettype none

interface rrd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_end;

  modport source (output valid, output data_byte, output frame_end, input ready);
  modport sink   (input valid, input data_byte, input frame_end, output ready);
endinterface

interface rrd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] row;
  logic [15:0] col;
  logic [15:0] length;
  logic [2:0]  ink;
  logic [15:0] width;
  logic [15:0] height;
  logic [1:0]  status;
  logic        last_of_item;

  modport source (output valid, output kind, output row, output col, output length,
                  output ink, output width, output height, output status,
                  output last_of_item, input ready);
  modport sink   (input valid, input kind, input row, input col, input length,
                  input ink, input width, input height, input status,
                  input last_of_item, output ready);
endinterface

`default_nettype wire

>>> rtl/row_repeat_rle_frame_decoder.sv
// Top level of the row-repeat run-length frame decoder (one encoded byte per beat).
// Results are written into the result queue when their byte is accepted.
// Throughput: one byte per cycle while each byte leaves at most one result and the
// receiver is ready; the rate is set by the four-entry result queue, which takes a
// byte only when room for three is left. Reset clears the decoder state to the header
// phase, empties the result queue and sets the capacity register to its full 24-bit value.
`default_nettype none

module row_repeat_rle_frame_decoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [23:0] cfg_data_i,
  rrd_in_if.sink           in_i,
  rrd_out_if.source        out_o
);

  // ---------------------------------------------------------------------------
  // Decoder state. Every field but the capacity register changes only when an input beat is accepted.
  // ---------------------------------------------------------------------------
  rrd_pkg::phase_e phase_q, phase_d;
  logic [2:0]      hidx_q, hidx_d;
  logic [15:0]     width_q, width_d;
  logic [15:0]     height_q, height_d;
  logic [15:0]     row_q, row_d;
  logic [15:0]     col_q, col_d;
  logic [16:0]     vval_q, vval_d;
  logic            vovf_q, vovf_d;
  logic [3:0]      vbytes_q, vbytes_d;
  logic [16:0]     repeat_q, repeat_d;
  logic [2:0]      ink_q, ink_d;
  logic [23:0]     cap_q;

  logic       in_fire;
  logic [7:0] b;

  assign in_fire = in_i.valid && in_i.ready;
  assign b       = in_i.data_byte;

  // ---------------------------------------------------------------------------
  // LEB128 step. The accumulated value saturates at the 17-bit limit; once a
  // byte pushes it past that, it stays saturated so every range check fails.
  // From the tenth byte on only 0 or 1 is legal.
  // ---------------------------------------------------------------------------
  logic [6:0]  payload;
  logic [23:0] shifted;
  logic [23:0] vor;
  logic        vf_err;
  logic        vf_done;
  logic        vf_ovf;
  logic [16:0] vf_val;

  always_comb begin
    payload = b[6:0];
    vf_err  = (vbytes_q >= 4'd9) && (b > 8'd1);
    vf_done = !b[7];
    unique case (vbytes_q)
      4'd0:    shifted = {17'd0, payload};
      4'd1:    shifted = {10'd0, payload, 7'd0};
      4'd2:    shifted = {3'd0, payload, 14'd0};
      default: shifted = '0;
    endcase
    vor    = {7'd0, vval_q} | shifted;
    vf_ovf = vovf_q ||
             ((payload != 7'd0) && ((vbytes_q >= 4'd3) || (vor > {7'd0, rrd_pkg::VarSat})));
    if (vf_ovf) begin
      vf_val = rrd_pkg::VarSat;
    end else if (payload != 7'd0) begin
      vf_val = vor[16:0];
    end else begin
      vf_val = vval_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Run placement. The run length comes either from the short form in the run
  // header byte or from the finished varint. A run that completes a row also
  // settles the repeat count against the rows still left in the frame.
  // ---------------------------------------------------------------------------
  logic [16:0] run_len;
  logic [2:0]  run_ink;
  logic [15:0] room;
  logic        run_bad;
  logic [16:0] col_sum;
  logic        row_end;
  logic        rep_bad;
  logic [16:0] row_sum;
  logic        frame_done;

  always_comb begin
    if (phase_q == rrd_pkg::PhRunHdr) begin
      run_len = {13'd0, b[3:0]} + 17'd1;
      run_ink = b[6:4];
    end else begin
      run_len = vf_val;
      run_ink = ink_q;
    end
    room       = width_q - col_q;
    run_bad    = (run_len == 17'd0) || (run_len > {1'b0, room});
    col_sum    = {1'b0, col_q} + {1'b0, run_len[15:0]};
    row_end    = col_sum >= {1'b0, width_q};
    rep_bad    = repeat_q > {1'b0, height_q - row_q};
    row_sum    = {1'b0, row_q} + repeat_q;
    frame_done = row_sum >= {1'b0, height_q};
  end

  // ---------------------------------------------------------------------------
  // Next state and the up to three results of the current byte. The first slot
  // holds the header or the fill run (never both), then a row copy, then the
  // one status that a byte can cause.
  // ---------------------------------------------------------------------------
  rrd_pkg::result_t r_first, r_copy, r_stat;
  logic             v_first, v_copy, v_stat;
  logic             bad;
  logic             do_run;
  logic [15:0]      hdr_height;
  logic [31:0]      area;

  always_comb begin
    phase_d  = phase_q;
    hidx_d   = hidx_q;
    width_d  = width_q;
    height_d = height_q;
    row_d    = row_q;
    col_d    = col_q;
    vval_d   = vval_q;
    vovf_d   = vovf_q;
    vbytes_d = vbytes_q;
    repeat_d = repeat_q;
    ink_d    = ink_q;
    r_first  = '0;
    r_copy   = '0;
    r_stat   = '0;
    v_first  = 1'b0;
    v_copy   = 1'b0;
    v_stat   = 1'b0;
    bad      = 1'b0;
    do_run   = 1'b0;

    // On the last header byte the height is completed by the byte itself.
    hdr_height = {height_q[7:0], b};
    area       = {16'd0, width_q} * {16'd0, hdr_height};

    unique case (phase_q)
      rrd_pkg::PhHeader: begin
        if (hidx_q < 3'd4) begin
          bad = b != rrd_pkg::magic_byte(hidx_q[1:0]);
        end else if (hidx_q < 3'd6) begin
          width_d = {width_q[7:0], b};
        end else begin
          height_d = hdr_height;
        end
        if (!bad) begin
          if (hidx_q == 3'd7) begin
            v_first        = 1'b1;
            r_first.kind   = rrd_pkg::KindHeader;
            r_first.width  = width_q;
            r_first.height = hdr_height;
            if ((width_q == 16'd0) || (hdr_height == 16'd0)) begin
              // An empty frame is complete as soon as its size is known.
              v_stat        = 1'b1;
              r_stat.kind   = rrd_pkg::KindStatus;
              r_stat.status = rrd_pkg::StOk;
              phase_d       = rrd_pkg::PhDiscard;
            end else if (area > {8'd0, cap_q}) begin
              v_stat        = 1'b1;
              r_stat.kind   = rrd_pkg::KindStatus;
              r_stat.status = rrd_pkg::StNoSpace;
              phase_d       = rrd_pkg::PhDiscard;
            end else begin
              phase_d  = rrd_pkg::PhRepeat;
              row_d    = '0;
              col_d    = '0;
              vval_d   = '0;
              vovf_d   = 1'b0;
              vbytes_d = '0;
            end
          end else begin
            hidx_d = hidx_q + 3'd1;
          end
        end
      end
      rrd_pkg::PhRepeat: begin
        if (vf_err) begin
          bad = 1'b1;
        end else begin
          vval_d = vf_val;
          vovf_d = vf_ovf;
          if (vf_done) begin
            if (vf_val == 17'd0) begin
              bad = 1'b1;
            end else begin
              repeat_d = vf_val;
              col_d    = '0;
              phase_d  = rrd_pkg::PhRunHdr;
            end
          end else begin
            vbytes_d = vbytes_q + 4'd1;
          end
        end
      end
      rrd_pkg::PhRunHdr: begin
        ink_d = b[6:4];
        if ({1'b0, b[6:4]} >= 4'(rrd_pkg::InkLimit)) begin
          bad = 1'b1;
        end else if (b[7]) begin
          vval_d   = '0;
          vovf_d   = 1'b0;
          vbytes_d = '0;
          phase_d  = rrd_pkg::PhRunLen;
        end else begin
          do_run = 1'b1;
        end
      end
      rrd_pkg::PhRunLen: begin
        if (vf_err) begin
          bad = 1'b1;
        end else begin
          vval_d = vf_val;
          vovf_d = vf_ovf;
          if (vf_done) begin
            do_run = 1'b1;
          end else begin
            vbytes_d = vbytes_q + 4'd1;
          end
        end
      end
      rrd_pkg::PhDone: begin
        // Any byte after the last row is trailing garbage.
        bad = 1'b1;
      end
      rrd_pkg::PhDiscard: begin
      end
      default: begin
      end
    endcase

    if (do_run) begin
      if (run_bad) begin
        bad = 1'b1;
      end else begin
        v_first        = 1'b1;
        r_first.kind   = rrd_pkg::KindFill;
        r_first.row    = row_q;
        r_first.col    = col_q;
        r_first.length = run_len[15:0];
        r_first.ink    = run_ink;
        col_d          = col_sum[15:0];
        if (!row_end) begin
          phase_d = rrd_pkg::PhRunHdr;
        end else if (rep_bad) begin
          bad = 1'b1;
        end else begin
          if (repeat_q > 17'd1) begin
            v_copy        = 1'b1;
            r_copy.kind   = rrd_pkg::KindCopy;
            r_copy.row    = row_q;
            r_copy.length = 16'(repeat_q - 17'd1);
          end
          row_d = row_sum[15:0];
          col_d = '0;
          if (frame_done) begin
            phase_d = rrd_pkg::PhDone;
          end else begin
            phase_d  = rrd_pkg::PhRepeat;
            vval_d   = '0;
            vovf_d   = 1'b0;
            vbytes_d = '0;
          end
        end
      end
    end

    if (bad) begin
      v_stat        = 1'b1;
      r_stat.kind   = rrd_pkg::KindStatus;
      r_stat.status = rrd_pkg::StBad;
      phase_d       = rrd_pkg::PhDiscard;
    end

    // The frame end always rearms the header parser. A frame that has not
    // reported yet reports now: ok only when its last row was complete.
    if (in_i.frame_end) begin
      if (phase_d != rrd_pkg::PhDiscard) begin
        v_stat        = 1'b1;
        r_stat.kind   = rrd_pkg::KindStatus;
        r_stat.status = (phase_d == rrd_pkg::PhDone) ? rrd_pkg::StOk : rrd_pkg::StBad;
      end
      phase_d = rrd_pkg::PhHeader;
      hidx_d  = '0;
    end

    // Mark the last result of this byte.
    if (v_stat) begin
      r_stat.last_of_item = 1'b1;
    end else if (v_copy) begin
      r_copy.last_of_item = 1'b1;
    end else begin
      r_first.last_of_item = v_first;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= rrd_pkg::PhHeader;
      hidx_q   <= '0;
      width_q  <= '0;
      height_q <= '0;
      row_q    <= '0;
      col_q    <= '0;
      vval_q   <= '0;
      vovf_q   <= 1'b0;
      vbytes_q <= '0;
      repeat_q <= '0;
      ink_q    <= '0;
    end else if (in_fire) begin
      phase_q  <= phase_d;
      hidx_q   <= hidx_d;
      width_q  <= width_d;
      height_q <= height_d;
      row_q    <= row_d;
      col_q    <= col_d;
      vval_q   <= vval_d;
      vovf_q   <= vovf_d;
      vbytes_q <= vbytes_d;
      repeat_q <= repeat_d;
      ink_q    <= ink_d;
    end
  end

  // Capacity is sampled at header end; software must write it between frames, unenforced.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= 24'hFFFFFF;
    end else if (cfg_we_i) begin
      cap_q <= cfg_data_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Result queue. A byte pushes all its results together; the output side pops
  // one beat per cycle while the receiver is ready. A byte is taken only while three
  // entries are free, so the head entry is never overwritten while it is offered.
  // ---------------------------------------------------------------------------
  rrd_pkg::result_t                 queue_q [rrd_pkg::OutDepth];
  logic [rrd_pkg::OutPtrW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [rrd_pkg::OutCntW-1:0]      count_q;
  logic [rrd_pkg::OutPtrW-1:0]      pos_copy, pos_stat;
  logic [1:0]                       push_n;
  logic                             pop;
  rrd_pkg::result_t                 head;

  assign pos_copy = rrd_pkg::OutPtrW'(v_first);
  assign pos_stat = rrd_pkg::OutPtrW'(v_first) + rrd_pkg::OutPtrW'(v_copy);
  assign push_n   = in_fire ? (2'(v_first) + 2'(v_copy) + 2'(v_stat)) : 2'd0;
  assign pop      = out_o.valid && out_o.ready;
  assign head     = queue_q[rd_ptr_q];

  assign in_i.ready = count_q <= rrd_pkg::OutCntW'(rrd_pkg::OutDepth - rrd_pkg::MaxPerBeat);

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      if (v_first) begin
        queue_q[wr_ptr_q] <= r_first;
      end
      if (v_copy) begin
        queue_q[wr_ptr_q + pos_copy] <= r_copy;
      end
      if (v_stat) begin
        queue_q[wr_ptr_q + pos_stat] <= r_stat;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + rrd_pkg::OutPtrW'(push_n);
      rd_ptr_q <= rd_ptr_q + rrd_pkg::OutPtrW'(pop);
      count_q  <= count_q + rrd_pkg::OutCntW'(push_n) - rrd_pkg::OutCntW'(pop);
    end
  end

  assign out_o.valid        = count_q != '0;
  assign out_o.kind         = head.kind;
  assign out_o.row          = head.row;
  assign out_o.col          = head.col;
  assign out_o.length       = head.length;
  assign out_o.ink          = head.ink;
  assign out_o.width        = head.width;
  assign out_o.height       = head.height;
  assign out_o.status       = head.status;
  assign out_o.last_of_item = head.last_of_item;

endmodule

`default_nettype wire

>>> rtl/rrd_checker.sv
// Port-level assertions for the frame decoder and the bind that attaches them.
`default_nettype none
`include "row_repeat_rle_frame_decoder_macros.svh"

module rrd_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [1:0]  out_kind_i,
  input wire logic [15:0] out_row_i,
  input wire logic [15:0] out_length_i,
  input wire logic [15:0] out_width_i,
  input wire logic [15:0] out_height_i,
  input wire logic        out_last_i
);

  logic        is_status, is_copy, is_empty_hdr;
  logic        stall;
  logic [35:0] held_beat;

  assign is_status    = out_kind_i == rrd_pkg::KindStatus;
  assign is_copy      = out_kind_i == rrd_pkg::KindCopy;
  assign is_empty_hdr = (out_kind_i == rrd_pkg::KindHeader) &&
                        ((out_width_i == 16'd0) || (out_height_i == 16'd0));
  assign stall        = out_valid_i && !out_ready_i;
  assign held_beat    = {out_valid_i, out_kind_i, out_row_i, out_length_i, out_last_i};

  // A stalled result beat stays on offer and keeps its contents.
  `RRD_ASSERT(a_stall_hold, stall |=> $stable(held_beat), "stalled result beat changed")

  // The status is always the last beat that its byte causes.
  `RRD_ASSERT(a_status_last, out_valid_i && is_status |-> out_last_i, "status beat not marked last")

  // An empty frame's header is followed by its status from the same byte.
  `RRD_ASSERT(a_empty_hdr, out_valid_i && is_empty_hdr |-> !out_last_i, "empty header marked last")

  // A copy is emitted only for a repeat count above one.
  `RRD_ASSERT(a_copy_len, out_valid_i && is_copy |-> out_length_i != 16'd0, "row copy of zero rows")

  // Nothing is offered while reset is held.
  `RRD_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !out_valid_i, "result offered during reset")

endmodule

bind row_repeat_rle_frame_decoder rrd_checker u_rrd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_kind_i   (out_o.kind),
  .out_row_i    (out_o.row),
  .out_length_i (out_o.length),
  .out_width_i  (out_o.width),
  .out_height_i (out_o.height),
  .out_last_i   (out_o.last_of_item)
);

`default_nettype wire

>>> verif/tb_row_repeat_rle_frame_decoder.sv
// Self-checking testbench of the row-repeat run-length frame decoder.
`timescale 1ns / 1ps

module tb_row_repeat_rle_frame_decoder;
  import rrd_pkg::*;

  // Timing of the run. The watchdog limit is far above the longest quiet stretch that a
  // correct run can show: the receiver hold-off plus the pause before a register write.
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned QuietLimit = 3000;
  localparam int unsigned CfgSettle  = 4;
  localparam int unsigned TailCycles = 10;
  localparam int unsigned PhaseBytes = 12;
  localparam int unsigned NumPhases  = 6;

  // The four signature bytes that open every frame, first byte in the top bits.
  localparam logic [31:0] SigBytes = 32'h5546_4232;

  // Faults that the random frame builder can put into a frame.
  typedef enum int {
    FltNone,
    FltMagic,
    FltTrunc,
    FltTrail,
    FltZeroRep,
    FltPastEnd,
    FltZeroLen,
    FltBigVarint,
    FltTenth,
    FltArea,
    FltNoise
  } fault_e;

  // One input beat. Rows with typed set carry the final status that they must cause.
  typedef struct packed {
    logic [7:0] data;
    logic       fin;
    logic       typed;
    status_e    st;
  } stim_t;

  localparam int unsigned DirCount = 24;

  // Directed frames. The first is 65535 pixels wide and one row high, filled by a
  // single long run of the largest length and ink, and then followed by a trailing
  // byte. The second breaks the signature on its first byte and has its remaining
  // byte discarded. The third has zero width, so it reports ok right after the header.
  localparam stim_t DirRows [DirCount] = '{
    '{8'h55, 1'b0, 1'b0, StOk}, '{8'h46, 1'b0, 1'b0, StOk},
    '{8'h42, 1'b0, 1'b0, StOk}, '{8'h32, 1'b0, 1'b0, StOk},
    '{8'hFF, 1'b0, 1'b0, StOk}, '{8'hFF, 1'b0, 1'b0, StOk},
    '{8'h00, 1'b0, 1'b0, StOk}, '{8'h01, 1'b0, 1'b0, StOk},
    '{8'h01, 1'b0, 1'b0, StOk}, '{8'hF5, 1'b0, 1'b0, StOk},
    '{8'hFF, 1'b0, 1'b0, StOk}, '{8'hFF, 1'b0, 1'b0, StOk},
    '{8'h03, 1'b0, 1'b0, StOk}, '{8'h00, 1'b1, 1'b1, StBad},
    '{8'h00, 1'b0, 1'b1, StBad}, '{8'hFF, 1'b1, 1'b0, StOk},
    '{8'h55, 1'b0, 1'b0, StOk}, '{8'h46, 1'b0, 1'b0, StOk},
    '{8'h42, 1'b0, 1'b0, StOk}, '{8'h32, 1'b0, 1'b0, StOk},
    '{8'h00, 1'b0, 1'b0, StOk}, '{8'h00, 1'b0, 1'b0, StOk},
    '{8'hFF, 1'b0, 1'b0, StOk}, '{8'hFF, 1'b1, 1'b1, StOk}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [23:0] cfg_data_i;

  rrd_in_if  byte_if ();
  rrd_out_if res_if ();

  row_repeat_rle_frame_decoder i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (byte_if),
    .out_o      (res_if)
  );

  // The decoder state as the predictor keeps it, reset values included.
  phase_e      dec_phase = PhHeader;
  logic [2:0]  hdr_idx   = '0;
  logic [15:0] frm_w     = '0;
  logic [15:0] frm_h     = '0;
  logic [15:0] cur_row   = '0;
  logic [15:0] cur_col   = '0;
  logic [16:0] vint_val  = '0;
  logic        vint_ovf  = 1'b0;
  logic [3:0]  vint_cnt  = '0;
  logic [16:0] row_rep   = '0;
  logic [2:0]  run_ink_q = '0;
  logic [23:0] cap_pix   = 24'hFF_FFFF;

  // Commands caused by the current byte, and every command still owed by the block.
  result_t byte_cmds[$];
  result_t pending_cmds[$];

  // Stimulus of the current phase and the bytes of the frame under construction.
  stim_t      plan[$];
  logic [7:0] frm_bytes[$];

  // Payload side information of the beat on offer: its typed final status, if any.
  logic        drv_typed = 1'b0;
  status_e     drv_status = StOk;

  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  int unsigned gap_pct = 29;
  int unsigned hold_left = 0;
  logic        hold_req = 1'b0;

  initial begin
    clk_i = 1'b0;
  end

  always #10 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------------

  // Appends one command for the current byte. A byte never causes more than three.
  function automatic void emit(kind_e k, logic [15:0] r, logic [15:0] c, logic [15:0] l,
                               logic [2:0] ik, logic [15:0] w, logic [15:0] h, status_e s);
    result_t cmd;
    if (byte_cmds.size() >= MaxPerBeat) return;
    cmd        = '0;
    cmd.kind   = k;
    cmd.row    = r;
    cmd.col    = c;
    cmd.length = l;
    cmd.ink    = ik;
    cmd.width  = w;
    cmd.height = h;
    cmd.status = s;
    byte_cmds.push_back(cmd);
  endfunction

  function automatic void vint_restart();
    vint_val = '0;
    vint_ovf = 1'b0;
    vint_cnt = '0;
  endfunction

  // Feeds one LEB128 byte. The value saturates once it no longer fits in 17 bits.
  // Returns 1 when the value is complete, 0 when more bytes follow, -1 on a bad
  // tenth byte.
  function automatic int vint_take(logic [7:0] b);
    int unsigned acc;
    int unsigned sh;
    if (vint_cnt >= 4'd9 && b > 8'd1) return -1;
    sh = 7 * 32'(vint_cnt);
    if (b[6:0] != 7'd0) begin
      if (sh >= 17) begin
        vint_ovf = 1'b1;
      end else begin
        acc = (32'(b[6:0]) << sh) | 32'(vint_val);
        if (acc > 32'(VarSat)) vint_ovf = 1'b1;
        else vint_val = acc[16:0];
      end
    end
    if (vint_ovf) vint_val = VarSat;
    if (!b[7]) return 1;
    vint_cnt = vint_cnt + 4'd1;
    return 0;
  endfunction

  // Places a run on the current row. When the row is full, the repeat count is checked
  // against the rows left and a copy command follows for repeats above one.
  // Returns 1 when the run or the repeat is malformed.
  function automatic logic place_run(int unsigned len);
    int unsigned room;
    room = 32'(frm_w) - 32'(cur_col);
    if (len == 0 || len > room) return 1'b1;
    emit(KindFill, cur_row, cur_col, len[15:0], run_ink_q, '0, '0, StOk);
    cur_col = cur_col + len[15:0];
    if (cur_col < frm_w) begin
      dec_phase = PhRunHdr;
      return 1'b0;
    end
    if (32'(row_rep) > 32'(frm_h) - 32'(cur_row)) return 1'b1;
    if (row_rep > 17'd1) emit(KindCopy, cur_row, '0, 16'(row_rep - 17'd1), '0, '0, '0, StOk);
    cur_row = cur_row + row_rep[15:0];
    cur_col = '0;
    if (cur_row >= frm_h) begin
      dec_phase = PhDone;
    end else begin
      dec_phase = PhRepeat;
      vint_restart();
    end
    return 1'b0;
  endfunction

  // Works out the commands that one accepted byte causes and advances the state.
  function automatic void decode_byte(logic [7:0] b, logic fin);
    logic       bad;
    int         r;
    logic [2:0] idx;
    bad = 1'b0;
    byte_cmds.delete();
    case (dec_phase)
      PhHeader: begin
        idx = hdr_idx;
        if (idx < 3'd4) begin
          if (b != SigBytes[31 - 8 * idx -: 8]) bad = 1'b1;
        end else if (idx < 3'd6) begin
          frm_w = {frm_w[7:0], b};
        end else begin
          frm_h = {frm_h[7:0], b};
        end
        if (!bad) begin
          if (idx == 3'd7) begin
            emit(KindHeader, '0, '0, '0, '0, frm_w, frm_h, StOk);
            // A frame without area is done at once; capacity does not matter then.
            if (frm_w == 16'd0 || frm_h == 16'd0) begin
              emit(KindStatus, '0, '0, '0, '0, '0, '0, StOk);
              dec_phase = PhDiscard;
            end else if (32'(frm_w) * 32'(frm_h) > 32'(cap_pix)) begin
              emit(KindStatus, '0, '0, '0, '0, '0, '0, StNoSpace);
              dec_phase = PhDiscard;
            end else begin
              dec_phase = PhRepeat;
              cur_row   = '0;
              cur_col   = '0;
              vint_restart();
            end
          end else begin
            hdr_idx = idx + 3'd1;
          end
        end
      end
      PhRepeat: begin
        r = vint_take(b);
        if (r < 0) begin
          bad = 1'b1;
        end else if (r > 0) begin
          if (vint_val == 17'd0) begin
            bad = 1'b1;
          end else begin
            row_rep   = vint_val;
            cur_col   = '0;
            dec_phase = PhRunHdr;
          end
        end
      end
      PhRunHdr: begin
        run_ink_q = b[6:4];
        if (32'(run_ink_q) >= InkLimit) begin
          bad = 1'b1;
        end else if (b[7]) begin
          vint_restart();
          dec_phase = PhRunLen;
        end else begin
          bad = place_run(32'(b[3:0]) + 1);
        end
      end
      PhRunLen: begin
        r = vint_take(b);
        if (r < 0) bad = 1'b1;
        else if (r > 0) bad = place_run(32'(vint_val));
      end
      PhDone: begin
        bad = 1'b1;
      end
      default: begin
      end
    endcase
    if (bad) begin
      emit(KindStatus, '0, '0, '0, '0, '0, '0, StBad);
      dec_phase = PhDiscard;
    end
    // The frame end always reports a status unless one has been sent already.
    if (fin) begin
      if (dec_phase != PhDiscard) begin
        emit(KindStatus, '0, '0, '0, '0, '0, '0, (dec_phase == PhDone) ? StOk : StBad);
      end
      dec_phase = PhHeader;
      hdr_idx   = '0;
    end
  endfunction

  // ---------------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------------

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Both sides are sampled at the rising edge, before the block updates. A result beat
  // accepted at an edge can only stem from bytes accepted at earlier edges, so the
  // result side is handled before the byte side.
  always @(posedge clk_i) begin
    result_t want;
    result_t cmd;
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        if (pending_cmds.size() == 0) begin
          $error("result beat with nothing expected: kind %0d", res_if.kind);
          mismatches++;
        end else begin
          want = pending_cmds.pop_front();
          check_field("kind", 32'(want.kind), 32'(res_if.kind));
          check_field("row", 32'(want.row), 32'(res_if.row));
          check_field("col", 32'(want.col), 32'(res_if.col));
          check_field("length", 32'(want.length), 32'(res_if.length));
          check_field("ink", 32'(want.ink), 32'(res_if.ink));
          check_field("width", 32'(want.width), 32'(res_if.width));
          check_field("height", 32'(want.height), 32'(res_if.height));
          check_field("status", 32'(want.status), 32'(res_if.status));
          check_field("last_of_item", 32'(want.last_of_item), 32'(res_if.last_of_item));
        end
      end
      if (byte_if.valid && byte_if.ready) begin
        decode_byte(byte_if.data_byte, byte_if.frame_end);
        // A directed row with a typed status replaces the predicted final status, so
        // that value is checked against the table rather than the predictor.
        if (drv_typed) begin
          if (byte_cmds.size() != 0 && byte_cmds[byte_cmds.size() - 1].kind == KindStatus) begin
            cmd = byte_cmds.pop_back();
          end
          cmd        = '0;
          cmd.kind   = KindStatus;
          cmd.status = drv_status;
          byte_cmds.push_back(cmd);
        end
        foreach (byte_cmds[k]) begin
          cmd = byte_cmds[k];
          cmd.last_of_item = (k == byte_cmds.size() - 1);
          pending_cmds.push_back(cmd);
        end
      end
    end
  end

  // The watchdog ends the run when no beat moves on either side for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (byte_if.valid && byte_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------------
  // Result receiver
  // ---------------------------------------------------------------------------------

  // Ready changes at the falling edge. A hold-off request keeps ready low for a long,
  // counted stretch so that the result queue fills and the byte input stalls.
  initial begin
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_left = HoldCycles;
        hold_req  = 1'b0;
      end
      if (hold_left != 0) begin
        res_if.ready = 1'b0;
        hold_left--;
      end else begin
        res_if.ready = ($urandom_range(99) >= gap_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------------

  // Offers one byte beat. Called at a falling edge and returns at a falling edge, so
  // valid stays high across back-to-back beats and is only lowered for a gap.
  task automatic send_byte(stim_t it);
    while ($urandom_range(99) < gap_pct) begin
      byte_if.valid = 1'b0;
      @(negedge clk_i);
    end
    byte_if.valid     = 1'b1;
    byte_if.data_byte = it.data;
    byte_if.frame_end = it.fin;
    drv_typed         = it.typed;
    drv_status        = it.st;
    do @(posedge clk_i); while (!byte_if.ready);
    @(negedge clk_i);
  endtask

  // Writes the capacity register once the block is idle. Bytes that cause no result
  // may still be inside the block after the last result, hence the short pause.
  task automatic set_capacity(logic [23:0] v);
    byte_if.valid = 1'b0;
    while (pending_cmds.size() != 0) @(negedge clk_i);
    repeat (CfgSettle) @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_data_i = v;
    cap_pix    = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Appends an LEB128 value, optionally stretched by extra bytes with zero payload.
  task automatic put_varint(int unsigned v, int unsigned pad);
    logic [6:0] grp;
    logic       more;
    do begin
      grp  = v[6:0];
      v    = v >> 7;
      more = (v != 0) || (pad != 0);
      frm_bytes.push_back({more, grp});
    end while (v != 0);
    while (pad != 0) begin
      pad--;
      frm_bytes.push_back({pad != 0, 7'd0});
    end
  endtask

  // Builds one random frame and appends it to the plan. Most frames are well formed;
  // the others carry one fault, placed on a random row where the fault is row based.
  task automatic gen_frame();
    fault_e      flt;
    int unsigned w, h, rw, cl, rep, len, room, frow, cut, idx;
    logic        hit, applied, stop;
    logic [2:0]  ink3;
    frm_bytes.delete();
    flt = ($urandom_range(99) < 60) ? FltNone : fault_e'($urandom_range(1, 10));
    if (flt == FltNoise) begin
      repeat ($urandom_range(1, 5)) frm_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      if ($urandom_range(7) == 0) begin
        w = $urandom_range(200, 65535);
        h = $urandom_range(1, 3);
      end else begin
        w = $urandom_range(1, 12);
        h = $urandom_range(1, 6);
      end
      if (flt == FltArea) begin
        case ($urandom_range(2))
          0: begin
            w = 0;
            h = $urandom_range(0, 65535);
          end
          1: h = 0;
          default: begin
            // At least 4096 by 4096, which is above any capacity.
            w = $urandom_range(4096, 65535);
            h = $urandom_range(4096, 65535);
          end
        endcase
      end
      for (int k = 0; k < 4; k++) frm_bytes.push_back(SigBytes[31 - 8 * k -: 8]);
      frm_bytes.push_back(w[15:8]);
      frm_bytes.push_back(w[7:0]);
      frm_bytes.push_back(h[15:8]);
      frm_bytes.push_back(h[7:0]);
      if (flt == FltArea) begin
        repeat ($urandom_range(0, 3)) frm_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
        frow    = $urandom_range(0, h - 1);
        applied = 1'b0;
        stop    = 1'b0;
        rw      = 0;
        while (rw < h && !stop) begin
          rep = ($urandom_range(3) == 0) ? $urandom_range(1, h - rw) : 1;
          hit = !applied && (rw + rep > frow);
          if (hit) applied = 1'b1;
          if (hit && flt == FltZeroRep) begin
            put_varint(0, $urandom_range(0, 1));
            stop = 1'b1;
          end else if (hit && flt == FltBigVarint) begin
            // Too many rows; large values also exercise saturation.
            put_varint($urandom_range(h - rw + 1, 32'hFFFF_FFFF), 0);
          end else if (hit && flt == FltTenth) begin
            // Nine continuation bytes, then a tenth byte of any value.
            repeat (9) frm_bytes.push_back(8'h80);
            frm_bytes.push_back(8'($urandom_range(0, 255)));
          end else begin
            put_varint(rep, ($urandom_range(5) == 0) ? 1 : 0);
          end
          cl = 0;
          while (cl < w && !stop) begin
            room = w - cl;
            if (room > 16 && $urandom_range(1) == 1) len = $urandom_range(1, room);
            else len = $urandom_range(1, (room < 16) ? room : 16);
            if (hit && flt == FltPastEnd && cl + len == w) len = room + $urandom_range(1, 3);
            if (hit && flt == FltZeroLen) begin
              len  = 0;
              stop = 1'b1;
            end
            ink3 = 3'($urandom_range(0, 7));
            if (len >= 1 && len <= 16 && $urandom_range(1) == 1) begin
              frm_bytes.push_back({1'b0, ink3, 4'(len - 1)});
            end else begin
              // Long form: the low nibble of the run byte carries no meaning.
              frm_bytes.push_back({1'b1, ink3, 4'($urandom_range(0, 15))});
              put_varint(len, ($urandom_range(7) == 0) ? 1 : 0);
            end
            cl += len;
          end
          rw += rep;
        end
      end
    end
    case (flt)
      FltMagic: begin
        idx = $urandom_range(0, 3);
        frm_bytes[idx] = frm_bytes[idx] ^ 8'($urandom_range(1, 255));
      end
      FltTrunc: begin
        // The frame end may even land on the last header byte.
        cut = $urandom_range(8, frm_bytes.size() - 1);
        while (frm_bytes.size() > cut) frm_bytes.pop_back();
      end
      FltTrail: frm_bytes.push_back(8'($urandom_range(0, 255)));
      default: begin
      end
    endcase
    foreach (frm_bytes[k]) begin
      plan.push_back('{frm_bytes[k], (k == frm_bytes.size() - 1), 1'b0, StOk});
    end
  endtask

  // ---------------------------------------------------------------------------------
  // Sequence of the run
  // ---------------------------------------------------------------------------------

  initial begin
    logic [23:0] cap;
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_data_i        = '0;
    byte_if.valid     = 1'b0;
    byte_if.data_byte = '0;
    byte_if.frame_end = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed frames at the capacity that reset leaves.
    for (int i = 0; i < DirCount; i++) send_byte(DirRows[i]);

    // Random phases, each at its own capacity. The extremes come first, then a small
    // capacity that rejects many frames. The first phase also carries the receiver
    // hold-off, and the third runs without any idle cycles on either side.
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: cap = 24'hFF_FFFF;
        1: cap = 24'd0;
        2: cap = 24'($urandom_range(1, 100));
        3: cap = 24'd36;
        4: cap = 24'($urandom_range(100, 24'hFF_FFFF));
        default: cap = 24'hFF_FFFF;
      endcase
      set_capacity(cap);
      gap_pct = (p == 2) ? 0 : 29;
      if (p == 0) hold_req = 1'b1;
      plan.delete();
      while (plan.size() < PhaseBytes) gen_frame();
      foreach (plan[i]) send_byte(plan[i]);
    end
    byte_if.valid = 1'b0;

    // Drain the outstanding commands, then watch a little longer for stray beats.
    while (pending_cmds.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (mismatches == 0 && pending_cmds.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
